FILE: hdl/tab_pkg.sv
// ----------------------------------------------------------------------------
// Triangle alignment package
// Shared widths, types, register indexes and the CORDIC gain constant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tab_pkg;

   // Coordinates inside the rotation datapath carry the CORDIC growth.
   localparam int CW         = 38;
   localparam int XW         = 32;
   localparam int FW         = 28;
   localparam int BARY_SHIFT = 5;
   localparam int NW         = 64;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [XW-1:0] word_type;

   typedef enum logic [1:0] {
      REG_ANCHOR_X = 2'd0,
      REG_ANCHOR_Y = 2'd1,
      REG_ANCHOR_Z = 2'd2
   } reg_index_type;

   localparam word_type RESET_ANCHOR_X = 32'sd281857229;
   localparam word_type RESET_ANCHOR_Y = 32'sd295279002;
   localparam word_type RESET_ANCHOR_Z = 32'sd0;

   typedef struct packed {
      coord_type e_x;
      coord_type e_y;
      coord_type a_x;
      coord_type a_y;
      coord_type s_x;
      coord_type s_y;
      coord_type s_z;
   } bary_in_type;

   typedef struct packed {
      logic     degenerate;
      word_type weight_a;
      word_type weight_f;
      word_type weight_e;
      word_type sample_z;
      word_type sample_y;
      word_type sample_x;
   } bary_out_type;

   // Inverse CORDIC gain in Q28, evaluated at elaboration time.
   function automatic logic [63:0] gain_inverse(input int stages);
      logic [63:0] p;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] num;
      logic [63:0] quo;
      logic [63:0] rem;
      p = 64'd1 << 30;
      for (int i = 0; i < stages; i++) begin
         p = p + (p >> (2 * i));
      end
      v     = p << 30;
      res   = '0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      if (res == 0) res = 64'd1;
      num = (64'd1 << 58) + (res >> 1);
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= res) begin
            rem    = rem - res;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

endpackage

FILE: hdl/tab_rotate.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC vectoring rotation
// Drives the q coordinate of the target pair (index 0) to zero and applies
// the same micro-rotations and gain correction to the other two pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tab_rotate #(
   parameter int STAGES = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tab_pkg::coord_type in_p [3],
   input  tab_pkg::coord_type in_q [3],
   input  tab_pkg::coord_type in_r [3],
   output logic               out_valid,
   output tab_pkg::coord_type out_p [3],
   output tab_pkg::coord_type out_q [3],
   output tab_pkg::coord_type out_r [3]
);

   localparam int CW = tab_pkg::CW;
   localparam int FW = tab_pkg::FW;
   localparam int LW = 20;
   localparam int HW = CW - LW + FW + 1;
   localparam int OW = LW + FW + 2;
   localparam int PW = CW + FW + 2;
   localparam logic [63:0] INVK_FULL = tab_pkg::gain_inverse(STAGES);
   localparam logic signed [FW:0] INVK = $signed({1'b0, INVK_FULL[FW-1:0]});

   typedef logic signed [HW-1:0] hi_type;
   typedef logic signed [OW-1:0] lo_type;

   logic               v_ff    [STAGES+1];
   logic               skip_ff [STAGES+1];
   tab_pkg::coord_type p_ff    [STAGES+1][3];
   tab_pkg::coord_type q_ff    [STAGES+1][3];
   tab_pkg::coord_type r_ff    [STAGES+1][3];
   tab_pkg::coord_type p_in    [STAGES][3];
   tab_pkg::coord_type q_in    [STAGES][3];

   logic               pre_skip;
   logic               pre_neg;
   tab_pkg::coord_type pp_in [3];
   tab_pkg::coord_type pq_in [3];

   logic               v1_ff;
   logic               skip1_ff;
   hi_type             phi_ff [3];
   hi_type             qhi_ff [3];
   lo_type             plo_ff [3];
   lo_type             qlo_ff [3];
   tab_pkg::coord_type p1_ff  [3];
   tab_pkg::coord_type q1_ff  [3];
   tab_pkg::coord_type r1_ff  [3];

   logic               v2_ff;
   tab_pkg::coord_type po_ff [3];
   tab_pkg::coord_type qo_ff [3];
   tab_pkg::coord_type ro_ff [3];

   function automatic tab_pkg::coord_type gain_fix(input hi_type hi, input lo_type lo);
      logic signed [PW-1:0] acc;
      acc = (PW'(hi) <<< LW) + PW'(lo) + (PW'(1) <<< (FW - 1));
      return acc[FW+CW-1:FW];
   endfunction

   // A zero-length target pair means no rotation at all, gain included.
   always_comb begin
      pre_skip = (in_p[0] == '0) && (in_q[0] == '0);
      pre_neg  = in_p[0][CW-1];
      for (int k = 0; k < 3; k++) begin
         pp_in[k] = pre_neg ? -in_p[k] : in_p[k];
         pq_in[k] = pre_neg ? -in_q[k] : in_q[k];
      end
   end

   always_comb begin
      tab_pkg::coord_type sp;
      tab_pkg::coord_type sq;
      logic               dir;
      for (int i = 0; i < STAGES; i++) begin
         dir = !q_ff[i][0][CW-1];
         for (int k = 0; k < 3; k++) begin
            sp = q_ff[i][k] >>> i;
            sq = p_ff[i][k] >>> i;
            if (skip_ff[i]) begin
               p_in[i][k] = p_ff[i][k];
               q_in[i][k] = q_ff[i][k];
            end else if (dir) begin
               p_in[i][k] = p_ff[i][k] + sp;
               q_in[i][k] = q_ff[i][k] - sq;
            end else begin
               p_in[i][k] = p_ff[i][k] - sp;
               q_in[i][k] = q_ff[i][k] + sq;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STAGES; i++) v_ff[i] <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < STAGES; i++) v_ff[i+1] <= v_ff[i];
         v1_ff <= v_ff[STAGES];
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         skip_ff[0] <= pre_skip;
         for (int k = 0; k < 3; k++) begin
            p_ff[0][k] <= pp_in[k];
            q_ff[0][k] <= pq_in[k];
            r_ff[0][k] <= in_r[k];
         end
         for (int i = 0; i < STAGES; i++) begin
            skip_ff[i+1] <= skip_ff[i];
            for (int k = 0; k < 3; k++) begin
               p_ff[i+1][k] <= p_in[i][k];
               q_ff[i+1][k] <= q_in[i][k];
               r_ff[i+1][k] <= r_ff[i][k];
            end
         end
         // Gain correction is split into a high and a low partial product.
         skip1_ff <= skip_ff[STAGES];
         for (int k = 0; k < 3; k++) begin
            phi_ff[k] <= $signed(p_ff[STAGES][k][CW-1:LW]) * INVK;
            plo_ff[k] <= $signed({1'b0, p_ff[STAGES][k][LW-1:0]}) * INVK;
            qhi_ff[k] <= $signed(q_ff[STAGES][k][CW-1:LW]) * INVK;
            qlo_ff[k] <= $signed({1'b0, q_ff[STAGES][k][LW-1:0]}) * INVK;
            p1_ff[k]  <= p_ff[STAGES][k];
            q1_ff[k]  <= q_ff[STAGES][k];
            r1_ff[k]  <= r_ff[STAGES][k];
         end
         for (int k = 0; k < 3; k++) begin
            po_ff[k] <= skip1_ff ? p1_ff[k] : gain_fix(phi_ff[k], plo_ff[k]);
            qo_ff[k] <= skip1_ff ? q1_ff[k] : gain_fix(qhi_ff[k], qlo_ff[k]);
            ro_ff[k] <= r1_ff[k];
         end
      end
   end

   assign out_valid = v2_ff;
   assign out_p     = po_ff;
   assign out_q     = qo_ff;
   assign out_r     = ro_ff;

endmodule

FILE: hdl/tab_divide.sv
// ----------------------------------------------------------------------------
// Pipelined signed fractional divider
// Gives num / den in Q28, truncated toward zero and saturated to 32 bits,
// one restoring step per stage. A side payload travels along unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tab_divide #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [tab_pkg::NW-1:0] in_num,
   input  logic signed [tab_pkg::NW-1:0] in_den,
   input  logic                          in_zero,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output tab_pkg::word_type             out_quo,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int NW    = tab_pkg::NW;
   localparam int FW    = tab_pkg::FW;
   localparam int RW    = NW + 4;
   localparam int STEPS = FW + 3;

   logic [NW-1:0] abs_num;
   logic [NW-1:0] abs_den;

   logic              v0_ff;
   logic [RW-1:0]     un_ff;
   logic [RW-1:0]     ud0_ff;
   logic              neg0_ff;
   logic              zero0_ff;
   logic [SIDE_W-1:0] side0_ff;

   logic              v_ff    [STEPS+1];
   logic [RW-1:0]     r_ff    [STEPS+1];
   logic [STEPS-1:0]  m_ff    [STEPS+1];
   logic [RW-1:0]     ud_ff   [STEPS+1];
   logic              neg_ff  [STEPS+1];
   logic              zero_ff [STEPS+1];
   logic              sat_ff  [STEPS+1];
   logic [SIDE_W-1:0] side_ff [STEPS+1];
   logic [RW-1:0]     r_in    [STEPS];
   logic [STEPS-1:0]  m_in    [STEPS];

   logic              vo_ff;
   tab_pkg::word_type quo_ff;
   logic [SIDE_W-1:0] sideo_ff;

   assign abs_num = in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
   assign abs_den = in_den[NW-1] ? NW'(-in_den) : NW'(in_den);

   // The first three steps give the integer bits, the rest the fraction.
   always_comb begin
      logic [RW-1:0] rr;
      logic [RW-1:0] trial;
      logic          take;
      for (int t = 0; t < STEPS; t++) begin
         if (t < 3) begin
            rr    = r_ff[t];
            trial = ud_ff[t] << (2 - t);
         end else begin
            rr    = r_ff[t] << 1;
            trial = ud_ff[t];
         end
         take    = (rr >= trial);
         r_in[t] = take ? rr - trial : rr;
         m_in[t] = {m_ff[t][STEPS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         for (int t = 0; t <= STEPS; t++) v_ff[t] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v0_ff   <= in_valid;
         v_ff[0] <= v0_ff;
         for (int t = 0; t < STEPS; t++) v_ff[t+1] <= v_ff[t];
         vo_ff   <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         un_ff    <= RW'(abs_num);
         ud0_ff   <= RW'(abs_den);
         neg0_ff  <= in_num[NW-1] ^ in_den[NW-1];
         zero0_ff <= in_zero;
         side0_ff <= in_side;

         r_ff[0]    <= un_ff;
         m_ff[0]    <= '0;
         ud_ff[0]   <= ud0_ff;
         neg_ff[0]  <= neg0_ff;
         zero_ff[0] <= zero0_ff;
         sat_ff[0]  <= (un_ff >= (ud0_ff << 3));
         side_ff[0] <= side0_ff;

         for (int t = 0; t < STEPS; t++) begin
            r_ff[t+1]    <= r_in[t];
            m_ff[t+1]    <= m_in[t];
            ud_ff[t+1]   <= ud_ff[t];
            neg_ff[t+1]  <= neg_ff[t];
            zero_ff[t+1] <= zero_ff[t];
            sat_ff[t+1]  <= sat_ff[t];
            side_ff[t+1] <= side_ff[t];
         end

         if (zero_ff[STEPS]) begin
            quo_ff <= '0;
         end else if (sat_ff[STEPS]) begin
            quo_ff <= neg_ff[STEPS] ? {1'b1, {(tab_pkg::XW-1){1'b0}}}
                                    : {1'b0, {(tab_pkg::XW-1){1'b1}}};
         end else if (neg_ff[STEPS]) begin
            quo_ff <= -$signed({1'b0, m_ff[STEPS]});
         end else begin
            quo_ff <= $signed({1'b0, m_ff[STEPS]});
         end
         sideo_ff <= side_ff[STEPS];
      end
   end

   assign out_valid = vo_ff;
   assign out_quo   = quo_ff;
   assign out_side  = sideo_ff;

endmodule

FILE: hdl/tab_bary.sv
// ----------------------------------------------------------------------------
// Barycentric weights and output offset
// Forms the determinant and numerators from the aligned points, divides,
// and adds the anchor to the aligned sample with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tab_bary (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  tab_pkg::bary_in_type  in_pts,
   input  tab_pkg::word_type     anchor_x,
   input  tab_pkg::word_type     anchor_y,
   input  tab_pkg::word_type     anchor_z,
   output logic                  out_valid,
   output tab_pkg::bary_out_type out_res
);

   localparam int CW = tab_pkg::CW;
   localparam int XW = tab_pkg::XW;
   localparam int NW = tab_pkg::NW;
   localparam int DW = CW - tab_pkg::BARY_SHIFT + 1;
   localparam int SW = CW + 2;
   localparam int SMP_W = 3 * XW;

   typedef logic signed [DW-1:0]   diff_type;
   typedef logic signed [2*DW-1:0] prod_type;
   typedef logic signed [2*DW:0]   sum_type;
   typedef logic signed [SW-1:0]   wide_type;

   function automatic tab_pkg::word_type clamp_word(input wide_type v);
      if (v > wide_type'({1'b0, {(XW-1){1'b1}}})) return {1'b0, {(XW-1){1'b1}}};
      if (v < -wide_type'({1'b0, {(XW-1){1'b1}}}) - wide_type'(1)) begin
         return {1'b1, {(XW-1){1'b0}}};
      end
      return v[XW-1:0];
   endfunction

   tab_pkg::coord_type x1, y1, x3, y3, xp, yp;
   tab_pkg::coord_type da_in, db_in, dd_in, de_in, df_in, dg_in;

   logic              v0_ff;
   diff_type          da_ff, db_ff, dc_ff, dd_ff, de_ff, df_ff, dg_ff;
   logic [SMP_W-1:0]  smp0_ff;

   logic              v1_ff;
   prod_type          pab_ff, pcd_ff, pae_ff, pcf_ff, pge_ff, pbf_ff;
   logic [SMP_W-1:0]  smp1_ff;

   logic              v2_ff;
   sum_type           det_ff, ne_ff, nf_ff;
   logic              zero2_ff;
   logic [SMP_W-1:0]  smp2_ff;

   logic              ve, vf;
   tab_pkg::word_type we, wf;
   logic [SMP_W-1:0]  smp_d;
   logic              degen_d;

   logic              vo_ff;
   tab_pkg::bary_out_type res_ff;

   // F sits at the origin of the aligned frame, so its terms drop out.
   assign x1 = in_pts.e_x >>> tab_pkg::BARY_SHIFT;
   assign y1 = in_pts.e_y >>> tab_pkg::BARY_SHIFT;
   assign x3 = in_pts.a_x >>> tab_pkg::BARY_SHIFT;
   assign y3 = in_pts.a_y >>> tab_pkg::BARY_SHIFT;
   assign xp = in_pts.s_x >>> tab_pkg::BARY_SHIFT;
   assign yp = in_pts.s_y >>> tab_pkg::BARY_SHIFT;

   assign da_in = -y3;
   assign db_in = x1 - x3;
   assign dd_in = y1 - y3;
   assign de_in = xp - x3;
   assign df_in = yp - y3;
   assign dg_in = y3 - y1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         vo_ff <= ve & vf;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         da_ff   <= da_in[DW-1:0];
         db_ff   <= db_in[DW-1:0];
         dc_ff   <= x3[DW-1:0];
         dd_ff   <= dd_in[DW-1:0];
         de_ff   <= de_in[DW-1:0];
         df_ff   <= df_in[DW-1:0];
         dg_ff   <= dg_in[DW-1:0];
         smp0_ff <= {clamp_word(SW'(in_pts.s_z) + SW'(anchor_z)),
                     clamp_word(SW'(in_pts.s_y) + SW'(anchor_y)),
                     clamp_word(SW'(in_pts.s_x) + SW'(anchor_x))};

         pab_ff  <= da_ff * db_ff;
         pcd_ff  <= dc_ff * dd_ff;
         pae_ff  <= da_ff * de_ff;
         pcf_ff  <= dc_ff * df_ff;
         pge_ff  <= dg_ff * de_ff;
         pbf_ff  <= db_ff * df_ff;
         smp1_ff <= smp0_ff;

         det_ff   <= sum_type'(pab_ff) + sum_type'(pcd_ff);
         ne_ff    <= sum_type'(pae_ff) + sum_type'(pcf_ff);
         nf_ff    <= sum_type'(pge_ff) + sum_type'(pbf_ff);
         zero2_ff <= (pab_ff + pcd_ff) == '0;
         smp2_ff  <= smp1_ff;
      end
   end

   tab_divide #(
      .SIDE_W (SMP_W)
   ) u_div_e (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_num    ($signed(ne_ff[NW-1:0])),
      .in_den    ($signed(det_ff[NW-1:0])),
      .in_zero   (zero2_ff),
      .in_side   (smp2_ff),
      .out_valid (ve),
      .out_quo   (we),
      .out_side  (smp_d)
   );

   tab_divide #(
      .SIDE_W (1)
   ) u_div_f (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_num    ($signed(nf_ff[NW-1:0])),
      .in_den    ($signed(det_ff[NW-1:0])),
      .in_zero   (zero2_ff),
      .in_side   (zero2_ff),
      .out_valid (vf),
      .out_quo   (wf),
      .out_side  (degen_d)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.sample_x   <= smp_d[XW-1:0];
         res_ff.sample_y   <= smp_d[2*XW-1:XW];
         res_ff.sample_z   <= smp_d[3*XW-1:2*XW];
         res_ff.weight_e   <= we;
         res_ff.weight_f   <= wf;
         res_ff.weight_a   <= degen_d ? '0 :
            clamp_word((wide_type'(1) <<< tab_pkg::FW) - SW'(we) - SW'(wf));
         res_ff.degenerate <= degen_d;
      end
   end

   assign out_valid = vo_ff;
   assign out_res   = res_ff;

endmodule

FILE: hdl/triangle_align_barycentric.sv
// ----------------------------------------------------------------------------
// Triangle alignment with barycentric weights
// Accepts one transfer per clock while the output is not stalled and returns
// one result per input. The latency is set by the three CORDIC vectoring
// rotations, each CORDIC_STAGES+3 deep, and the 31-step restoring divider of
// the weights. The whole pipeline holds while a finished result waits to be
// taken. All values are signed Q3.28; anchor registers must be written through
// the csr port only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_align_barycentric #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic         clock,
   input  logic         reset,
   // ref_e_x, ref_e_y, ref_e_z, ref_f_x, ref_f_y, ref_f_z,
   // ref_a_x, ref_a_y, ref_a_z, sample_in_x, sample_in_y, sample_in_z
   input  logic [383:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_out_x, sample_out_y, sample_out_z, weight_e, weight_f, weight_a
   output logic [191:0] rsp_tdata,
   // degenerate
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wr_data
);

   localparam int XW = tab_pkg::XW;

   typedef struct packed {
      tab_pkg::coord_type x;
      tab_pkg::coord_type y;
      tab_pkg::coord_type z;
   } point_type;

   tab_pkg::word_type anchor_x_ff, anchor_y_ff, anchor_z_ff;

   logic      en;
   logic      t_valid_ff;
   point_type e_ff, a_ff, s_ff;

   tab_pkg::coord_type r1_p [3], r1_q [3], r1_r [3];
   tab_pkg::coord_type o1_p [3], o1_q [3], o1_r [3];
   tab_pkg::coord_type r2_p [3], r2_q [3], r2_r [3];
   tab_pkg::coord_type o2_p [3], o2_q [3], o2_r [3];
   tab_pkg::coord_type r3_p [3], r3_q [3], r3_r [3];
   tab_pkg::coord_type o3_p [3], o3_q [3], o3_r [3];
   logic v1, v2, v3;

   tab_pkg::bary_in_type  bary_in;
   tab_pkg::bary_out_type bary_out;
   logic                  bary_valid;

   function automatic tab_pkg::coord_type field(input logic [383:0] d, input int idx);
      return tab_pkg::coord_type'($signed(d[idx*XW +: XW]));
   endfunction

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_x_ff <= tab_pkg::RESET_ANCHOR_X;
         anchor_y_ff <= tab_pkg::RESET_ANCHOR_Y;
         anchor_z_ff <= tab_pkg::RESET_ANCHOR_Z;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tab_pkg::REG_ANCHOR_X: anchor_x_ff <= csr_wr_data;
            tab_pkg::REG_ANCHOR_Y: anchor_y_ff <= csr_wr_data;
            tab_pkg::REG_ANCHOR_Z: anchor_z_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Move F to the origin; differences are exact in the wide format.
   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (en) begin
         t_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff.x <= field(req_tdata, 0) - field(req_tdata, 3);
         e_ff.y <= field(req_tdata, 1) - field(req_tdata, 4);
         e_ff.z <= field(req_tdata, 2) - field(req_tdata, 5);
         a_ff.x <= field(req_tdata, 6) - field(req_tdata, 3);
         a_ff.y <= field(req_tdata, 7) - field(req_tdata, 4);
         a_ff.z <= field(req_tdata, 8) - field(req_tdata, 5);
         s_ff.x <= field(req_tdata, 9) - field(req_tdata, 3);
         s_ff.y <= field(req_tdata, 10) - field(req_tdata, 4);
         s_ff.z <= field(req_tdata, 11) - field(req_tdata, 5);
      end
   end

   // Lane order in every rotation: target point first, then the other two.
   // First rotation: about z, pair (x, y), target A.
   always_comb begin
      r1_p = '{a_ff.x, e_ff.x, s_ff.x};
      r1_q = '{a_ff.y, e_ff.y, s_ff.y};
      r1_r = '{a_ff.z, e_ff.z, s_ff.z};
   end

   tab_rotate #(.STAGES (CORDIC_STAGES)) u_rot_z (
      .clock (clock), .reset (reset), .en (en), .in_valid (t_valid_ff),
      .in_p (r1_p), .in_q (r1_q), .in_r (r1_r),
      .out_valid (v1), .out_p (o1_p), .out_q (o1_q), .out_r (o1_r)
   );

   // Second rotation: about y, pair (x, z), target A.
   always_comb begin
      r2_p = o1_p;
      r2_q = o1_r;
      r2_r = o1_q;
   end

   tab_rotate #(.STAGES (CORDIC_STAGES)) u_rot_y (
      .clock (clock), .reset (reset), .en (en), .in_valid (v1),
      .in_p (r2_p), .in_q (r2_q), .in_r (r2_r),
      .out_valid (v2), .out_p (o2_p), .out_q (o2_q), .out_r (o2_r)
   );

   // Third rotation: about x, pair (y, z), target E. Lanes become E, A, S.
   always_comb begin
      r3_p = '{o2_r[1], o2_r[0], o2_r[2]};
      r3_q = '{o2_q[1], o2_q[0], o2_q[2]};
      r3_r = '{o2_p[1], o2_p[0], o2_p[2]};
   end

   tab_rotate #(.STAGES (CORDIC_STAGES)) u_rot_x (
      .clock (clock), .reset (reset), .en (en), .in_valid (v2),
      .in_p (r3_p), .in_q (r3_q), .in_r (r3_r),
      .out_valid (v3), .out_p (o3_p), .out_q (o3_q), .out_r (o3_r)
   );

   always_comb begin
      bary_in.e_x = o3_r[0];
      bary_in.e_y = o3_p[0];
      bary_in.a_x = o3_r[1];
      bary_in.a_y = o3_p[1];
      bary_in.s_x = o3_r[2];
      bary_in.s_y = o3_p[2];
      bary_in.s_z = o3_q[2];
   end

   tab_bary u_bary (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3),
      .in_pts    (bary_in),
      .anchor_x  (anchor_x_ff),
      .anchor_y  (anchor_y_ff),
      .anchor_z  (anchor_z_ff),
      .out_valid (bary_valid),
      .out_res   (bary_out)
   );

   assign rsp_tvalid = bary_valid;
   assign rsp_tdata  = {bary_out.weight_a, bary_out.weight_f, bary_out.weight_e,
                        bary_out.sample_z, bary_out.sample_y, bary_out.sample_x};
   assign rsp_tuser  = bary_out.degenerate;

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[191:96] == '0)
      else $error("degenerate result carries nonzero weights");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_anchor_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && csr_index == tab_pkg::REG_ANCHOR_X |=>
         anchor_x_ff == $past(csr_wr_data))
      else $error("anchor_x write lost");

endmodule

FILE: sim/tab_checker.sv
// ----------------------------------------------------------------------------
// Triangle alignment result checker
// Watches the request, response and register ports of the block. For every
// request transfer it works out the aligned sample and the barycentric weights
// and queues them; every response transfer is compared with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tab_checker #(
   parameter int STAGES = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [383:0] req_tdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [191:0] rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wr_data,
   output int           fail_count,
   output int           pending
);

   typedef struct {
      logic [31:0] sx, sy, sz, we, wf, wa;
      logic        degen;
   } aligned_type;

   aligned_type aligned_q[$];
   logic [31:0] anchor [3];
   longint      inv_gain;
   longint      pts [3][3];   // E, A, S relative to F

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   initial begin
      longint unsigned prod, root;
      prod = 64'd1 << 30;
      for (int i = 0; i < STAGES; i++) prod = prod + (prod >> (2 * i));
      root = int_sqrt(prod << 30);
      if (root == 0) root = 1;
      inv_gain = ((64'd1 << 58) + (root >> 1)) / root;
   end

   function automatic longint scale_gain(input longint v);
      return (v * inv_gain + (64'sd1 <<< 27)) >>> 28;
   endfunction

   // Vectoring rotation that zeroes coordinate qi of point tgt; the same
   // micro-rotations are applied to all three points.
   function void vector_rotate(input int pi, input int qi, input int tgt);
      longint p, q, sp, sq;
      logic   cw;
      if (pts[tgt][pi] == 0 && pts[tgt][qi] == 0) return;
      if (pts[tgt][pi] < 0)
         for (int k = 0; k < 3; k++) begin
            pts[k][pi] = -pts[k][pi];
            pts[k][qi] = -pts[k][qi];
         end
      for (int i = 0; i < STAGES; i++) begin
         cw = pts[tgt][qi] >= 0;
         for (int k = 0; k < 3; k++) begin
            p  = pts[k][pi];
            q  = pts[k][qi];
            sp = q >>> i;
            sq = p >>> i;
            pts[k][pi] = cw ? p + sp : p - sp;
            pts[k][qi] = cw ? q - sq : q + sq;
         end
      end
      for (int k = 0; k < 3; k++) begin
         pts[k][pi] = scale_gain(pts[k][pi]);
         pts[k][qi] = scale_gain(pts[k][qi]);
      end
   endfunction

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint weight_quotient(input longint num, input longint den);
      logic            neg;
      longint unsigned un, ud, q, r, mag;
      neg = (num < 0) != (den < 0);
      un  = num < 0 ? -num : num;
      ud  = den < 0 ? -den : den;
      q   = un / ud;
      r   = un % ud;
      if (q >= 8) return neg ? -64'sd2147483648 : 64'sd2147483647;
      mag = q;
      for (int b = 0; b < 28; b++) begin
         r   = r << 1;
         mag = mag << 1;
         if (r >= ud) begin
            r   = r - ud;
            mag = mag | 1;
         end
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function aligned_type align_item(input logic [383:0] d);
      aligned_type res;
      longint      f [3];
      longint      x1, y1, x3, y3, xp, yp, det, ne, nf, we, wf;
      for (int c = 0; c < 3; c++) begin
         f[c]      = longint'($signed(d[32*(3+c) +: 32]));
         pts[0][c] = longint'($signed(d[32*c +: 32])) - f[c];
         pts[1][c] = longint'($signed(d[32*(6+c) +: 32])) - f[c];
         pts[2][c] = longint'($signed(d[32*(9+c) +: 32])) - f[c];
      end
      vector_rotate(0, 1, 1);
      vector_rotate(0, 2, 1);
      vector_rotate(1, 2, 0);
      res.sx = 32'(sat32(pts[2][0] + longint'($signed(anchor[0]))));
      res.sy = 32'(sat32(pts[2][1] + longint'($signed(anchor[1]))));
      res.sz = 32'(sat32(pts[2][2] + longint'($signed(anchor[2]))));
      x1 = pts[0][0] >>> 5;  y1 = pts[0][1] >>> 5;
      x3 = pts[1][0] >>> 5;  y3 = pts[1][1] >>> 5;
      xp = pts[2][0] >>> 5;  yp = pts[2][1] >>> 5;
      // F sits at the origin of the rotated frame.
      det = (-y3) * (x1 - x3) + x3 * (y1 - y3);
      if (det == 0) begin
         res.we = '0; res.wf = '0; res.wa = '0; res.degen = 1'b1;
      end else begin
         ne = (-y3) * (xp - x3) + x3 * (yp - y3);
         nf = (y3 - y1) * (xp - x3) + (x1 - x3) * (yp - y3);
         we = weight_quotient(ne, det);
         wf = weight_quotient(nf, det);
         res.we    = 32'(we);
         res.wf    = 32'(wf);
         res.wa    = 32'(sat32((64'sd1 <<< 28) - we - wf));
         res.degen = 1'b0;
      end
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      aligned_type exp_r;
      if (reset) begin
         anchor[0] <= tab_pkg::RESET_ANCHOR_X;
         anchor[1] <= tab_pkg::RESET_ANCHOR_Y;
         anchor[2] <= tab_pkg::RESET_ANCHOR_Z;
      end else begin
         if (req_tvalid && req_tready) aligned_q.push_back(align_item(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (aligned_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               exp_r = aligned_q.pop_front();
               compare_field("sample_out_x", exp_r.sx, rsp_tdata[31:0]);
               compare_field("sample_out_y", exp_r.sy, rsp_tdata[63:32]);
               compare_field("sample_out_z", exp_r.sz, rsp_tdata[95:64]);
               compare_field("weight_e", exp_r.we, rsp_tdata[127:96]);
               compare_field("weight_f", exp_r.wf, rsp_tdata[159:128]);
               compare_field("weight_a", exp_r.wa, rsp_tdata[191:160]);
               compare_field("degenerate", 32'(exp_r.degen), 32'(rsp_tuser[0]));
            end
         end
         if (csr_wr_en) begin
            case (tab_pkg::reg_index_type'(csr_index))
               tab_pkg::REG_ANCHOR_X: anchor[0] <= csr_wr_data;
               tab_pkg::REG_ANCHOR_Y: anchor[1] <= csr_wr_data;
               tab_pkg::REG_ANCHOR_Z: anchor[2] <= csr_wr_data;
               default: ;
            endcase
         end
      end
      pending <= aligned_q.size();
   end

   initial fail_count = 0;

endmodule

FILE: sim/tb_triangle_align_barycentric.sv
// ----------------------------------------------------------------------------
// Triangle alignment testbench
// Drives directed and random triangles through the block under random gaps
// and response stalls, rewrites the anchor between phases, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_align_barycentric;

   localparam int PHASE_ITEMS = 410;
   localparam int TAIL_CYCLES = 200;

   logic         clock;
   logic         reset;
   logic [383:0] req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_wr_en;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wr_data;
   int           fail_count;
   int           pending;
   int           taken;

   triangle_align_barycentric DUT (.*);

   tab_checker CHECK (.*);

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // Coordinate of moderate size, within about +/-2.0.
   function automatic logic [31:0] near_coord();
      return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
   endfunction

   function automatic logic [383:0] random_triangle();
      logic [383:0] d;
      int           mode;
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 12; k++) d[32*k +: 32] = near_coord();
      case (mode)
         0, 1: for (int k = 0; k < 12; k++) d[32*k +: 32] = $urandom();
         2:    for (int k = 0; k < 12; k++) d[32*k +: 32] = 32'($signed(4'($urandom())));
         3:    d[95:0] = d[191:96];                 // E on F
         4:    d[287:192] = d[191:96];              // A on F
         5:    for (int k = 0; k < 3; k++)          // E midway on F-A line
                  d[32*k +: 32] = 32'(($signed(d[32*(3+k) +: 32])
                                      + $signed(d[32*(6+k) +: 32])) >>> 1);
         6:    for (int k = 9; k < 12; k++) d[32*k +: 32] = $urandom();
         default: ;
      endcase
      return d;
   endfunction

   task automatic send_item(input logic [383:0] d);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_anchor(input logic [31:0] ax, input logic [31:0] ay,
                               input logic [31:0] az);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (130) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= tab_pkg::REG_ANCHOR_X;  csr_wr_data <= ax;
      @(negedge clock);
      csr_index <= tab_pkg::REG_ANCHOR_Y;  csr_wr_data <= ay;
      @(negedge clock);
      csr_index <= tab_pkg::REG_ANCHOR_Z;  csr_wr_data <= az;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Response side: random stalls, and one long hold that backs the pipe up.
   initial begin
      int wait_cycles;
      rsp_tready = 1'b0;
      taken      = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = ((taken / 150) % 2 == 1) ? 0 : $urandom_range(0, 9);
         if (taken == 300) wait_cycles = 600;
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      logic [383:0] d;
      logic [31:0]  lo, hi;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = tab_pkg::REG_ANCHOR_X;
      csr_wr_data = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items under the reset anchor.
      lo = 32'h8000_0000;
      hi = 32'h7FFF_FFFF;
      send_item('0);                                   // everything at the origin
      send_item({12{hi}});
      send_item({12{lo}});
      send_item({{3{hi}}, {3{lo}}, {3{32'h0}}, {3{hi}}});
      send_item({{3{lo}}, {3{hi}}, {3{32'h0}}, {3{lo}}});
      // A left of F: the first rotation starts with a half turn.
      send_item({32'h0, 32'h0, 32'h1000_0000, 32'h0, 32'h0, 32'hF000_0000,
                 96'h0, 32'h0, 32'h1000_0000, 32'h0});
      // Right triangle with the sample inside it.
      send_item({32'h0, 32'h0400_0000, 32'h0400_0000, 32'h0, 32'h0, 32'h1000_0000,
                 96'h0, 32'h0, 32'h1000_0000, 32'h0});
      // A much smaller right triangle, sample far away so the weights clip.
      send_item({32'h0, hi, hi, 32'h0, 32'h0, 32'h0000_1000,
                 96'h0, 32'h0, 32'h0000_1000, 32'h0});
      send_item({32'h0, lo, lo, 32'h0, 32'h0, 32'h0000_1000,
                 96'h0, 32'h0, 32'h0000_1000, 32'h0});
      // E on the F-A line: collinear.
      send_item({96'h0, 32'h0, 32'h0, 32'h2000_0000, 96'h0, 32'h0, 32'h0, 32'h1000_0000});
      // A straight above F along z only.
      send_item({96'h0123_4567_89AB_CDEF_0246_8ACE, 32'h1000_0000, 64'h0, 96'h0,
                 32'h0, 32'h1000_0000, 32'h0});
      // E straight below: last rotation flips the sign of the pair.
      send_item({96'h0, 32'h0, 32'h0, 32'h1000_0000, 96'h0, 32'h0, 32'hF000_0000, 32'h0});
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_triangle());

      write_anchor(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_triangle());
      write_anchor(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_triangle());
      write_anchor($urandom(), $urandom(), $urandom());
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_triangle());

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
